// ===== hw/rtl/fpmd_pkg.sv =====
// ============================================================================
// fpmd_pkg
// Shared constants and types for the fiber pair maximum distance block.
// ============================================================================
package fpmd_pkg;

    // Default point count of one resampled fiber.
    localparam int POINTS_DEF = 21;

    // Default coordinate width, signed, 1/64 mm units.
    localparam int COORD_BITS_DEF = 16;

    // Width of the distance field of a result word.
    localparam int DIST_BITS = 17;

    // Status of the square root unit as seen by the sequencer.
    typedef struct packed {
        logic busy;       // A root is running or its result is waiting.
        logic res_valid;  // The root is finished and can be taken.
    } fpmd_root_stat_t;

endpackage

// ===== hw/rtl/fpmd_in_if.sv =====
// ============================================================================
// fpmd_in_if
// Point pair channel: one point of fiber A and one of fiber B per word.
// ============================================================================
interface fpmd_in_if #(
    parameter int COORD_BITS = fpmd_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z,
        input  ready
    );

    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z,
        output ready
    );
endinterface

// ===== hw/rtl/fpmd_out_if.sv =====
// ============================================================================
// fpmd_out_if
// Result channel: one distance word per fiber pair.
// ============================================================================
interface fpmd_out_if;
    logic                           valid;
    logic                           ready;
    logic [fpmd_pkg::DIST_BITS-1:0] distance;
    logic                           reversed_chosen;

    modport source (
        output valid, distance, reversed_chosen,
        input  ready
    );

    modport sink (
        input  valid, distance, reversed_chosen,
        output ready
    );
endinterface

// ===== hw/rtl/fiber_pair_max_distance.sv =====
// ============================================================================
// fiber_pair_max_distance
// Maximum point distance between two resampled fibers, direct and flipped.
// ============================================================================
// One input word carries point k of fiber A and point k of fiber B; a fiber
// pair is exactly POINTS words, and its last word causes one result word with
// the floor square root of the smaller of the two squared maxima (direct and
// reversed order) and a flag that is set when the reversed order gave it
// (a tie goes to the direct order). The first half of both fibers sits in an
// on-chip memory with a registered read port; reversed pairs are formed from
// it once the partner point arrives. All squared distances go through one
// shared multiplier, one axis per cycle, so a word in the first half of a pair
// goes through accept, three axes and accumulate, and a word in the second
// half computes three distances. The last word of a pair then hands the
// minimum to the square root unit once that unit is free, and the root runs
// in the background while the next pair streams in. The
// memory needs no initialization after reset: every entry is written earlier
// in the same pair before it is read.
// ============================================================================
module fiber_pair_max_distance #(
    parameter int POINTS     = fpmd_pkg::POINTS_DEF,
    parameter int COORD_BITS = fpmd_pkg::COORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fpmd_in_if.sink      points,
    fpmd_out_if.source   result
);
    import fpmd_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int SQ_W    = 2 * C + 2;
    localparam int R_W     = SQ_W / 2;
    localparam int EXT_W   = (R_W > DIST_BITS) ? R_W : DIST_BITS;
    localparam int HALF    = (POINTS + 1) / 2;
    localparam int HALF_AW = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int CNT_W   = $clog2(POINTS);
    localparam int MID_IDX = (POINTS - 1) / 2;
    localparam bit ODD     = (POINTS % 2) == 1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // Distance passes of one word.
    localparam logic [1:0] PASS_DIRECT = 2'd0;
    localparam logic [1:0] PASS_A_RB   = 2'd1;
    localparam logic [1:0] PASS_RA_B   = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   rev_reg;
    logic                   mid_reg;
    logic                   last_reg;
    logic [1:0]             pass_reg;
    logic [1:0]             axis_reg;

    logic [2:0][C-1:0]      a_reg;
    logic [2:0][C-1:0]      b_reg;
    logic [2:0][C-1:0]      rd_a_reg;
    logic [2:0][C-1:0]      rd_b_reg;
    logic [6*C-1:0]         half_mem [HALF];

    logic [SQ_W-1:0]        sq_reg;
    logic                   sq_vld_reg;
    logic                   sq_first_reg;
    logic                   sq_last_reg;
    logic [1:0]             sq_pass_reg;
    logic [SQ_W-1:0]        acc_reg;
    logic [SQ_W-1:0]        max_dir_reg;
    logic [SQ_W-1:0]        max_rev_reg;
    logic                   chosen_reg;

    logic                   out_valid_reg;
    logic [DIST_BITS-1:0]   dist_reg;
    logic                   out_rev_reg;

    logic                   accept;
    logic                   in_store;
    logic                   in_rev;
    logic                   in_mid;
    logic                   in_last;
    logic [CNT_W-1:0]       partner;
    logic [HALF_AW-1:0]     wr_addr;
    logic [HALF_AW-1:0]     rd_addr;
    logic [2:0][C-1:0]      in_a;
    logic [2:0][C-1:0]      in_b;
    logic                   pass_done;

    logic signed [C-1:0]    p_sel;
    logic signed [C-1:0]    q_sel;
    logic signed [C:0]      diff;
    logic signed [SQ_W-1:0] prod;
    logic [SQ_W-1:0]        d_sum;

    logic                   rev_lt;
    logic [SQ_W-1:0]        min_sq;
    logic                   root_start;
    logic                   root_take;
    fpmd_root_stat_t        root_stat;
    logic [R_W-1:0]         root_val;
    logic [EXT_W-1:0]       root_ext;

    // Input word decode.
    assign accept   = points.valid && points.ready;
    assign in_a     = {points.a_z, points.a_y, points.a_x};
    assign in_b     = {points.b_z, points.b_y, points.b_x};
    assign in_store = (count_reg < CNT_W'(HALF));
    assign in_rev   = !in_store;
    assign in_mid   = ODD && (count_reg == CNT_W'(MID_IDX));
    assign in_last  = (count_reg == CNT_W'(POINTS - 1));
    assign partner  = CNT_W'(POINTS - 1) - count_reg;
    assign wr_addr  = count_reg[HALF_AW-1:0];
    assign rd_addr  = partner[HALF_AW-1:0];

    assign points.ready = (state_reg == S_IDLE);

    // The last axis of the last pass ends the distance work of a word.
    assign pass_done = (axis_reg == AXIS_Z) && ((pass_reg == PASS_RA_B) || !rev_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (points.valid)
                begin
                    state_next = S_RUN;
                    count_next = in_last ? '0 : count_reg + CNT_W'(1);
                end
            end
            S_RUN:
            begin
                if (pass_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!root_stat.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            mid_reg    <= 1'b0;
            last_reg   <= 1'b0;
            pass_reg   <= PASS_DIRECT;
            axis_reg   <= AXIS_X;
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sq_vld_reg <= (state_reg == S_RUN);
            if (accept)
            begin
                rev_reg  <= in_rev;
                mid_reg  <= in_mid;
                last_reg <= in_last;
                pass_reg <= PASS_DIRECT;
                axis_reg <= AXIS_X;
            end
            else if (state_reg == S_RUN)
            begin
                if (axis_reg == AXIS_Z)
                begin
                    axis_reg <= AXIS_X;
                    pass_reg <= (pass_reg == PASS_DIRECT) ? PASS_A_RB : PASS_RA_B;
                end
                else
                begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end
        end
    end

    // Point registers and the first-half memory with its registered read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= in_a;
            b_reg <= in_b;
            if (in_store)
            begin
                half_mem[wr_addr] <= {in_b, in_a};
            end
            if (in_rev)
            begin
                {rd_b_reg, rd_a_reg} <= half_mem[rd_addr];
            end
        end
    end

    // Operand selection and the shared squaring multiplier.
    always_comb
    begin
        case (pass_reg)
            PASS_A_RB:
            begin
                p_sel = a_reg[axis_reg];
                q_sel = rd_b_reg[axis_reg];
            end
            PASS_RA_B:
            begin
                p_sel = rd_a_reg[axis_reg];
                q_sel = b_reg[axis_reg];
            end
            default:
            begin
                p_sel = a_reg[axis_reg];
                q_sel = b_reg[axis_reg];
            end
        endcase
    end

    assign diff = {p_sel[C-1], p_sel} - {q_sel[C-1], q_sel};
    assign prod = diff * diff;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RUN)
        begin
            sq_reg       <= $unsigned(prod);
            sq_first_reg <= (axis_reg == AXIS_X);
            sq_last_reg  <= (axis_reg == AXIS_Z);
            sq_pass_reg  <= pass_reg;
        end
    end

    // Axis accumulation.
    assign d_sum = (sq_first_reg ? '0 : acc_reg) + sq_reg;

    always_ff @(posedge clk)
    begin
        if (sq_vld_reg)
        begin
            acc_reg <= d_sum;
        end
    end

    // Running maxima; the middle point also counts for the reversed order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dir_reg <= '0;
            max_rev_reg <= '0;
        end
        else if (root_start)
        begin
            max_dir_reg <= '0;
            max_rev_reg <= '0;
        end
        else if (sq_vld_reg && sq_last_reg)
        begin
            if (sq_pass_reg == PASS_DIRECT)
            begin
                if (d_sum > max_dir_reg)
                begin
                    max_dir_reg <= d_sum;
                end
                if (mid_reg && (d_sum > max_rev_reg))
                begin
                    max_rev_reg <= d_sum;
                end
            end
            else if (d_sum > max_rev_reg)
            begin
                max_rev_reg <= d_sum;
            end
        end
    end

    // Hand the smaller maximum to the root unit at the end of a pair.
    assign rev_lt     = (max_rev_reg < max_dir_reg);
    assign min_sq     = rev_lt ? max_rev_reg : max_dir_reg;
    assign root_start = (state_reg == S_FIN) && !root_stat.busy;

    always_ff @(posedge clk)
    begin
        if (root_start)
        begin
            chosen_reg <= rev_lt;
        end
    end

    fpmd_isqrt #(
        .IN_W (SQ_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (root_start),
        .value     (min_sq),
        .res_ready (root_take),
        .stat      (root_stat),
        .root      (root_val)
    );

    // Output register.
    assign root_take = !out_valid_reg || result.ready;
    assign root_ext  = EXT_W'(root_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (root_stat.res_valid && root_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_stat.res_valid && root_take)
        begin
            dist_reg    <= root_ext[DIST_BITS-1:0];
            out_rev_reg <= chosen_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.distance        = dist_reg;
    assign result.reversed_chosen = out_rev_reg;

endmodule

// ===== hw/rtl/fpmd_isqrt.sv =====
// ============================================================================
// fpmd_isqrt
// Iterative floor square root, one result bit per cycle, with a held result.
// ============================================================================
module fpmd_isqrt #(
    parameter int IN_W = 34
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [IN_W-1:0]               value,
    input  logic                          res_ready,
    output fpmd_pkg::fpmd_root_stat_t     stat,
    output logic [IN_W/2-1:0]             root
);
    import fpmd_pkg::*;

    localparam int R_W    = IN_W / 2;
    localparam int REM_W  = R_W + 3;
    localparam int ITER_W = $clog2(R_W);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_BUSY = 2'd1;
    localparam logic [1:0] R_DONE = 2'd2;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [ITER_W-1:0] iter_reg;
    logic [IN_W-1:0]   val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [R_W-1:0]    root_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Bring down the next two bits of the radicand and try the next root bit.
    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[IN_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    // Sequencing of one root.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    phase_next = R_BUSY;
                end
            end
            R_BUSY:
            begin
                if (iter_reg == ITER_W'(R_W - 1))
                begin
                    phase_next = R_DONE;
                end
            end
            R_DONE:
            begin
                if (res_ready)
                begin
                    phase_next = R_IDLE;
                end
            end
            default:
            begin
                phase_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= R_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg == R_IDLE)
            begin
                iter_reg <= '0;
            end
            else if (phase_reg == R_BUSY)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
        end
    end

    // Radicand, remainder and partial root.
    always_ff @(posedge clk)
    begin
        if (phase_reg == R_IDLE && start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (phase_reg == R_BUSY)
        begin
            val_reg  <= {val_reg[IN_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[R_W-2:0], take};
        end
    end

    assign stat.busy      = (phase_reg != R_IDLE);
    assign stat.res_valid = (phase_reg == R_DONE);
    assign root           = root_reg;

endmodule

// ===== hw/rtl/fpmd_checker.sv =====
// ============================================================================
// fpmd_checker
// Port-level checks of the fiber pair maximum distance block.
// ============================================================================
module fpmd_checker #(
    parameter int POINTS = fpmd_pkg::POINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [fpmd_pkg::DIST_BITS-1:0] distance,
    input  logic                           reversed_chosen
);
    import fpmd_pkg::*;

    localparam int CNT_W = $clog2(POINTS);

    logic [CNT_W-1:0] idx_reg;
    logic [1:0]       pend_reg;
    logic             in_acc;
    logic             out_acc;
    logic             pair_end;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign pair_end = in_acc && (idx_reg == CNT_W'(POINTS - 1));

    // Word index within the pair and count of finished pairs not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                idx_reg <= pair_end ? '0 : idx_reg + CNT_W'(1);
            end
            if (pair_end && !out_acc)
            begin
                pend_reg <= pend_reg + 2'd1;
            end
            else if (!pair_end && out_acc)
            begin
                pend_reg <= pend_reg - 2'd1;
            end
        end
    end

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(reversed_chosen))
        else $error("result word changed while stalled");

    // A word keeps the sequencer busy for at least the cycle after it.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input taken in the cycle after a word");

    // A result word only appears for a finished pair.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result word without a finished pair");

    // With three finished pairs in flight the input must be stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd3 |-> !in_ready)
        else $error("input accepted with all result slots full");

endmodule

bind fiber_pair_max_distance fpmd_checker #(
    .POINTS (POINTS)
) u_fpmd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (points.valid),
    .in_ready        (points.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .distance        (result.distance),
    .reversed_chosen (result.reversed_chosen)
);
